@@ design/ultrasonic_tilt_estimator_top_macros.svh @@
// ---------------------------------------------------------------------------
// Ultrasonic tilt estimator assertion macros
// Shorthands for clocked assertions that are disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef ULTRASONIC_TILT_ESTIMATOR_TOP_MACROS_SVH
`define ULTRASONIC_TILT_ESTIMATOR_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UTE_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UTE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/ute_pkg.sv @@
// ---------------------------------------------------------------------------
// Ultrasonic tilt estimator package
// Widths, constants, register codes and beat types shared by the block.
// ---------------------------------------------------------------------------
`default_nettype none

package ute_pkg;

   localparam int CELL_COUNT_DEF = 10;
   localparam int NUM_LANES      = 4;

   localparam int TIME_W   = 15;
   localparam int SPEED_W  = 11;
   localparam int ALPHA_W  = 10;
   localparam int WEIGHT_W = 15;
   localparam int BASE_W   = 15;
   localparam int FLAGS_W  = 3;
   localparam int DIST_W   = 15;
   localparam int TILT_W   = 16;
   localparam int CELL_W   = 8;
   localparam int SEEN_W   = 4;

   localparam int FLAG_TIME  = 0;
   localparam int FLAG_DIST  = 1;
   localparam int FLAG_PLANE = 2;

   localparam logic [ALPHA_W-1:0] ALPHA_ONE  = 10'd1000;
   localparam logic [TIME_W-1:0]  TIME_LIMIT = 15'd32000;
   localparam int                 SPEED_DIV  = 2000;
   localparam logic [DIST_W-1:0]  DIST_MAX   = 15'd32767;

   // Shared restoring divider and square-root unit sizes.
   localparam int DIV_NUM_W = 30;
   localparam int DIV_DEN_W = 16;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W);
   localparam int SQ_N_W    = 31;
   localparam int SQ_R_W    = 16;

   // Division by 125 as a reciprocal multiply, exact for arguments below 2**23.
   // Dividing by 1000 or 2000 first drops the low three or four bits.
   localparam int                 RCP_IN_W = 23;
   localparam int                 RCP_M_W  = 24;
   localparam int                 RCP_S    = 30;
   localparam int                 Q125_W   = 17;
   localparam logic [RCP_M_W-1:0] RCP125_M = 24'd8589935;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      REG_SOUND_SPEED = 3'd0,
      REG_MAX_TIME    = 3'd1,
      REG_ALPHA       = 3'd2,
      REG_WEIGHT_X    = 3'd3,
      REG_WEIGHT_Y    = 3'd4,
      REG_BASELINE_X  = 3'd5,
      REG_BASELINE_Y  = 3'd6,
      REG_FLAGS       = 3'd7
   } csr_index_type;

   localparam logic [SPEED_W-1:0]  SOUND_SPEED_RST = 11'd343;
   localparam logic [TIME_W-1:0]   MAX_TIME_RST    = 15'd20000;
   localparam logic [ALPHA_W-1:0]  ALPHA_RST       = 10'd400;
   localparam logic [WEIGHT_W-1:0] WEIGHT_RST      = 15'd100;
   localparam logic [BASE_W-1:0]   BASELINE_RST    = 15'd100;
   localparam logic [FLAGS_W-1:0]  FLAGS_RST       = 3'd0;

   typedef struct packed {
      logic [SPEED_W-1:0]  sound_speed;
      logic [TIME_W-1:0]   max_time;
      logic [ALPHA_W-1:0]  alpha;
      logic [ALPHA_W-1:0]  alpha_rest;
      logic [WEIGHT_W-1:0] weight_x;
      logic [WEIGHT_W-1:0] weight_y;
      logic [BASE_W-1:0]   baseline_x;
      logic [BASE_W-1:0]   baseline_y;
      logic [FLAGS_W-1:0]  flags;
   } cfg_type;

   typedef struct packed {
      logic [TIME_W-1:0] echo_left_us;
      logic [TIME_W-1:0] echo_right_us;
      logic [TIME_W-1:0] echo_up_us;
      logic [TIME_W-1:0] echo_down_us;
      logic [SEEN_W-1:0] echo_seen;
   } req_payload_type;

   typedef struct packed {
      logic [DIST_W-1:0]        dist_left;
      logic [DIST_W-1:0]        dist_right;
      logic [DIST_W-1:0]        dist_up;
      logic [DIST_W-1:0]        dist_down;
      logic signed [TILT_W-1:0] tilt_x;
      logic signed [TILT_W-1:0] tilt_y;
      logic [DIST_W-1:0]        height;
      logic signed [CELL_W-1:0] cell_x;
      logic signed [CELL_W-1:0] cell_y;
   } rsp_payload_type;

   function automatic logic [Q125_W-1:0] div125(logic [RCP_IN_W-1:0] x);
      logic [RCP_IN_W+RCP_M_W-1:0] p;
      p = (RCP_IN_W+RCP_M_W)'(x) * (RCP_IN_W+RCP_M_W)'(RCP125_M);
      return p[RCP_S +: Q125_W];
   endfunction

endpackage

`default_nettype wire

@@ design/ute_div.sv @@
// ---------------------------------------------------------------------------
// Restoring divider
// Unsigned quotient, one bit per cycle, pulses done when the quotient is ready.
// ---------------------------------------------------------------------------
`default_nettype none

module ute_div import ute_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 go,
   input  logic [DIV_NUM_W-1:0] num,
   input  logic [DIV_DEN_W-1:0] den,
   output logic                 done,
   output logic [DIV_NUM_W-1:0] quo
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_NUM_W-1:0] q_ff, q_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W:0]   trial;
   logic [DIV_DEN_W:0]   diff;
   logic                 fits;

   always_comb begin
      trial   = {rem_ff, q_ff[DIV_NUM_W-1]};
      fits    = trial >= {1'b0, den_ff};
      diff    = trial - {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      den_in  = den_ff;
      if (go) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_NUM_W - 1);
         rem_in  = '0;
         q_in    = num;
         den_in  = den;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
         q_in   = {q_ff[DIV_NUM_W-2:0], fits};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = q_ff;

endmodule

`default_nettype wire

@@ design/ute_sqrt.sv @@
// ---------------------------------------------------------------------------
// Integer square root
// Floor square root by trial bits, most significant first, one per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module ute_sqrt import ute_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              go,
   input  logic [SQ_N_W-1:0] n,
   output logic              done,
   output logic [SQ_R_W-1:0] root
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [SQ_N_W-1:0]     n_ff, n_in;
   logic [SQ_R_W-1:0]     g_ff, g_in;
   logic [SQ_R_W-1:0]     bit_ff, bit_in;
   logic [SQ_R_W-1:0]     trial;
   logic [2*SQ_R_W-1:0]   square;

   always_comb begin
      trial   = g_ff | bit_ff;
      square  = (2*SQ_R_W)'(trial) * (2*SQ_R_W)'(trial);
      busy_in = busy_ff;
      done_in = 1'b0;
      n_in    = n_ff;
      g_in    = g_ff;
      bit_in  = bit_ff;
      if (go) begin
         busy_in = 1'b1;
         n_in    = n;
         g_in    = '0;
         bit_in  = SQ_R_W'(1) << (SQ_R_W - 1);
      end else if (busy_ff) begin
         if (square <= (2*SQ_R_W)'(n_ff)) begin
            g_in = trial;
         end
         bit_in = bit_ff >> 1;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      n_ff   <= n_in;
      g_ff   <= g_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = g_ff;

endmodule

`default_nettype wire

@@ design/ute_lane.sv @@
// ---------------------------------------------------------------------------
// Echo channel lane
// Timeout substitution, optional time smoothing, time to distance conversion
// with saturation and optional distance smoothing for one sensor.
// ---------------------------------------------------------------------------
`default_nettype none

module ute_lane import ute_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [TIME_W-1:0] echo_us,
   input  logic              seen,
   input  cfg_type           cfg,
   output logic              done,
   output logic [DIST_W-1:0] dist_mm
);

   localparam int ACC_W = 25;

   typedef enum logic [3:0] {
      L_IDLE, L_TB1, L_TB2, L_TBW, L_DM, L_DW, L_DB1, L_DB2, L_DBW, L_DONE
   } lane_state_type;

   lane_state_type       state_ff, state_in;
   logic [TIME_W-1:0]    t_ff, t_in;
   logic [TIME_W-1:0]    ft_ff, ft_in;
   logic [DIST_W-1:0]    dist_ff, dist_in;
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [RCP_IN_W-1:0]  rcp_arg;
   logic [Q125_W-1:0]    q125;
   logic [DIST_W-1:0]    dist_sat;

   always_comb begin
      // The distance step divides by 2000, the smoothing steps by 1000.
      rcp_arg  = (state_ff == L_DW) ? num_ff[RCP_IN_W+3:4] : num_ff[RCP_IN_W+2:3];
      q125     = div125(rcp_arg);
      dist_sat = (|q125[Q125_W-1:DIST_W]) ? DIST_MAX : q125[DIST_W-1:0];
      state_in = state_ff;
      t_in     = t_ff;
      ft_in    = ft_ff;
      dist_in  = dist_ff;
      acc_in   = acc_ff;
      num_in   = num_ff;
      case (state_ff)
         L_IDLE: begin
            if (start) begin
               t_in     = seen ? echo_us : cfg.max_time;
               state_in = cfg.flags[FLAG_TIME] ? L_TB1 : L_DM;
            end
         end
         L_TB1: begin
            acc_in   = ACC_W'(cfg.alpha) * ACC_W'(t_ff);
            state_in = L_TB2;
         end
         L_TB2: begin
            num_in   = DIV_NUM_W'(acc_ff) + DIV_NUM_W'(cfg.alpha_rest) * DIV_NUM_W'(ft_ff);
            state_in = L_TBW;
         end
         L_TBW: begin
            t_in     = q125[TIME_W-1:0];
            state_in = L_DM;
         end
         L_DM: begin
            ft_in    = t_ff;
            num_in   = DIV_NUM_W'(t_ff) * DIV_NUM_W'(cfg.sound_speed);
            state_in = L_DW;
         end
         L_DW: begin
            if (cfg.flags[FLAG_DIST]) begin
               t_in     = dist_sat;
               state_in = L_DB1;
            end else begin
               dist_in  = dist_sat;
               state_in = L_DONE;
            end
         end
         L_DB1: begin
            acc_in   = ACC_W'(cfg.alpha) * ACC_W'(t_ff);
            state_in = L_DB2;
         end
         L_DB2: begin
            num_in   = DIV_NUM_W'(acc_ff) + DIV_NUM_W'(cfg.alpha_rest) * DIV_NUM_W'(dist_ff);
            state_in = L_DBW;
         end
         L_DBW: begin
            dist_in  = q125[DIST_W-1:0];
            state_in = L_DONE;
         end
         L_DONE: begin
            state_in = L_IDLE;
         end
         default: begin
            state_in = L_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         ft_ff    <= '0;
         dist_ff  <= '0;
      end else begin
         state_ff <= state_in;
         ft_ff    <= ft_in;
         dist_ff  <= dist_in;
      end
      t_ff   <= t_in;
      acc_ff <= acc_in;
      num_ff <= num_in;
   end

   assign done    = (state_ff == L_DONE);
   assign dist_mm = dist_ff;

endmodule

`default_nettype wire

@@ design/ute_merge.sv @@
// ---------------------------------------------------------------------------
// Lane merge stage
// Height from the four distances, tilt per axis through the shared square
// root and divider, optional plane smoothing and cell quantization.
// ---------------------------------------------------------------------------
`default_nettype none

module ute_merge import ute_pkg::*; #(
   parameter int CELL_COUNT = CELL_COUNT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIST_W-1:0] dist_lane [NUM_LANES],
   input  cfg_type           cfg,
   input  logic              ack,
   output logic              res_valid,
   output rsp_payload_type   res
);

   localparam int PACC_W = 27;
   localparam int SQ_W   = 2 * BASE_W;

   // Weight over the cell count by a reciprocal multiply, exact for 15-bit
   // weights and up to 128 cells.
   localparam int                  STEP_S   = WEIGHT_W + 7;
   localparam int                  STEP_M_W = STEP_S + 1;
   localparam logic [STEP_M_W-1:0] STEP_M   =
      STEP_M_W'((2**STEP_S + CELL_COUNT - 1) / CELL_COUNT);

   typedef enum logic [3:0] {
      M_IDLE, M_AXIS, M_SQ1, M_SQ2, M_SQW, M_MUL, M_MW, M_PB1,
      M_PB2, M_PBW, M_PSTORE, M_CS, M_CQ, M_CQW, M_OUT
   } merge_state_type;

   merge_state_type          state_ff, state_in;
   logic                     axis_ff, axis_in;
   logic [1:0]               k_ff, k_in;
   logic [DIST_W-1:0]        hg_ff, hg_in;
   logic [DIST_W-1:0]        h_ff, h_in;
   logic                     neg_ff, neg_in;
   logic [SQ_W-1:0]          sq_ff, sq_in;
   logic                     sq_go_ff, sq_go_in;
   logic [SQ_N_W-1:0]        sq_n_ff, sq_n_in;
   logic [SQ_R_W-1:0]        l_ff, l_in;
   logic                     go_ff, go_in;
   logic [DIV_NUM_W-1:0]     num_ff, num_in;
   logic [DIV_DEN_W-1:0]     den_ff, den_in;
   logic signed [TILT_W-1:0] tx_ff, tx_in;
   logic signed [TILT_W-1:0] ty_ff, ty_in;
   logic signed [TILT_W-1:0] ptx_ff, ptx_in;
   logic signed [TILT_W-1:0] pty_ff, pty_in;
   logic signed [TILT_W-1:0] phg_ff, phg_in;
   logic signed [PACC_W-1:0] acc_ff, acc_in;
   logic                     bsign_ff, bsign_in;
   logic [WEIGHT_W-1:0]      step_ff, step_in;
   logic signed [CELL_W-1:0] cx_ff, cx_in;
   logic signed [CELL_W-1:0] cy_ff, cy_in;

   logic                     sq_done;
   logic [SQ_R_W-1:0]        sq_root;
   logic                     div_done;
   logic [DIV_NUM_W-1:0]     div_quo;

   logic [DIST_W+1:0]        dist_sum;
   logic [DIST_W-1:0]        da, db;
   logic                     gt;
   logic [WEIGHT_W-1:0]      w_sel;
   logic [BASE_W-1:0]        b_sel;
   logic signed [TILT_W-1:0] t_sel;
   logic signed [TILT_W-1:0] pv, pold;
   logic signed [TILT_W-1:0] mag_s;
   logic signed [TILT_W-1:0] blend_r;
   logic signed [TILT_W-1:0] t_abs;
   logic signed [PACC_W-1:0] pa, pb, pr, po, psum, pmag;
   logic [Q125_W-1:0]        pq;
   logic [WEIGHT_W+STEP_M_W-1:0] step_prod;
   logic signed [CELL_W-1:0] cell_q;
   merge_state_type          after_axis;

   ute_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .go    (sq_go_ff),
      .n     (sq_n_ff),
      .done  (sq_done),
      .root  (sq_root)
   );

   ute_div u_div (
      .clock (clock),
      .reset (reset),
      .go    (go_ff),
      .num   (num_ff),
      .den   (den_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_comb begin
      dist_sum = (DIST_W+2)'(dist_lane[0]) + (DIST_W+2)'(dist_lane[1])
               + (DIST_W+2)'(dist_lane[2]) + (DIST_W+2)'(dist_lane[3]);
      da    = axis_ff ? dist_lane[2] : dist_lane[0];
      db    = axis_ff ? dist_lane[3] : dist_lane[1];
      gt    = da > db;
      w_sel = axis_ff ? cfg.weight_y : cfg.weight_x;
      b_sel = axis_ff ? cfg.baseline_y : cfg.baseline_x;
      t_sel = axis_ff ? ty_ff : tx_ff;
      t_abs = (t_sel < 0) ? -t_sel : t_sel;
      step_prod = (WEIGHT_W+STEP_M_W)'(w_sel) * (WEIGHT_W+STEP_M_W)'(STEP_M);

      case (k_ff)
         2'd0:    begin pv = tx_ff;           pold = ptx_ff; end
         2'd1:    begin pv = ty_ff;           pold = pty_ff; end
         default: begin pv = {1'b0, hg_ff};   pold = phg_ff; end
      endcase

      pa    = PACC_W'(signed'({1'b0, cfg.alpha}));
      pr    = PACC_W'(signed'({1'b0, cfg.alpha_rest}));
      pb    = PACC_W'(pv);
      po    = PACC_W'(pold);
      psum  = acc_ff + pr * po;
      pmag  = (psum < 0) ? -psum : psum;
      // The blend magnitude is held in num_ff and divided by 1000.
      pq      = div125(num_ff[RCP_IN_W+2:3]);
      blend_r = bsign_ff ? -signed'(pq[TILT_W-1:0]) : signed'(pq[TILT_W-1:0]);
      mag_s   = neg_ff ? -signed'({1'b0, div_quo[DIST_W-1:0]})
                       : signed'({1'b0, div_quo[DIST_W-1:0]});

      // Quotient magnitude clamped to the signed cell range.
      if (bsign_ff) begin
         cell_q = (div_quo > DIV_NUM_W'(128)) ? CELL_W'(-128) : -signed'(div_quo[CELL_W-1:0]);
      end else begin
         cell_q = (div_quo > DIV_NUM_W'(127)) ? CELL_W'(127) : signed'(div_quo[CELL_W-1:0]);
      end

      if (!axis_ff) begin
         after_axis = M_AXIS;
      end else if (cfg.flags[FLAG_PLANE]) begin
         after_axis = M_PB1;
      end else begin
         after_axis = M_PSTORE;
      end

      state_in = state_ff;
      axis_in  = axis_ff;
      k_in     = k_ff;
      hg_in    = hg_ff;
      h_in     = h_ff;
      neg_in   = neg_ff;
      sq_in    = sq_ff;
      sq_go_in = 1'b0;
      sq_n_in  = sq_n_ff;
      l_in     = l_ff;
      go_in    = 1'b0;
      num_in   = num_ff;
      den_in   = den_ff;
      tx_in    = tx_ff;
      ty_in    = ty_ff;
      ptx_in   = ptx_ff;
      pty_in   = pty_ff;
      phg_in   = phg_ff;
      acc_in   = acc_ff;
      bsign_in = bsign_ff;
      step_in  = step_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;

      case (state_ff)
         M_IDLE: begin
            if (start) begin
               hg_in    = dist_sum[DIST_W+1:2];
               axis_in  = 1'b0;
               k_in     = 2'd0;
               state_in = M_AXIS;
            end
         end
         M_AXIS: begin
            h_in = gt ? (da - db) : (db - da);
            // Horizontal is positive when left is farther, vertical when down is.
            neg_in   = axis_ff ? gt : !gt;
            state_in = M_SQ1;
         end
         M_SQ1: begin
            sq_in    = SQ_W'(b_sel) * SQ_W'(b_sel);
            state_in = M_SQ2;
         end
         M_SQ2: begin
            sq_n_in  = SQ_N_W'(sq_ff) + SQ_N_W'(h_ff) * SQ_N_W'(h_ff);
            sq_go_in = 1'b1;
            state_in = M_SQW;
         end
         M_SQW: begin
            if (sq_done) begin
               l_in     = sq_root;
               state_in = M_MUL;
            end
         end
         M_MUL: begin
            if (l_ff == '0) begin
               if (axis_ff) ty_in = '0;
               else         tx_in = '0;
               axis_in  = 1'b1;
               state_in = after_axis;
            end else begin
               num_in   = DIV_NUM_W'(w_sel) * DIV_NUM_W'(h_ff);
               den_in   = DIV_DEN_W'(l_ff);
               go_in    = 1'b1;
               state_in = M_MW;
            end
         end
         M_MW: begin
            if (div_done) begin
               if (axis_ff) ty_in = mag_s;
               else         tx_in = mag_s;
               axis_in  = 1'b1;
               state_in = after_axis;
            end
         end
         M_PB1: begin
            acc_in   = pa * pb;
            state_in = M_PB2;
         end
         M_PB2: begin
            bsign_in = psum < 0;
            num_in   = DIV_NUM_W'(pmag);
            state_in = M_PBW;
         end
         M_PBW: begin
            case (k_ff)
               2'd0:    tx_in = blend_r;
               2'd1:    ty_in = blend_r;
               default: hg_in = blend_r[DIST_W-1:0];
            endcase
            if (k_ff == 2'd2) begin
               state_in = M_PSTORE;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = M_PB1;
            end
         end
         M_PSTORE: begin
            ptx_in   = tx_ff;
            pty_in   = ty_ff;
            phg_in   = {1'b0, hg_ff};
            axis_in  = 1'b0;
            state_in = M_CS;
         end
         M_CS: begin
            step_in  = step_prod[STEP_S +: WEIGHT_W];
            state_in = M_CQ;
         end
         M_CQ: begin
            if (step_ff == '0) begin
               if (axis_ff) cy_in = '0;
               else         cx_in = '0;
               axis_in  = 1'b1;
               state_in = axis_ff ? M_OUT : M_CS;
            end else begin
               bsign_in = t_sel < 0;
               num_in   = DIV_NUM_W'(unsigned'(t_abs));
               den_in   = DIV_DEN_W'(step_ff);
               go_in    = 1'b1;
               state_in = M_CQW;
            end
         end
         M_CQW: begin
            if (div_done) begin
               if (axis_ff) cy_in = cell_q;
               else         cx_in = cell_q;
               axis_in  = 1'b1;
               state_in = axis_ff ? M_OUT : M_CS;
            end
         end
         M_OUT: begin
            if (ack) begin
               state_in = M_IDLE;
            end
         end
         default: begin
            state_in = M_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         go_ff    <= 1'b0;
         sq_go_ff <= 1'b0;
         ptx_ff   <= '0;
         pty_ff   <= '0;
         phg_ff   <= '0;
      end else begin
         state_ff <= state_in;
         go_ff    <= go_in;
         sq_go_ff <= sq_go_in;
         ptx_ff   <= ptx_in;
         pty_ff   <= pty_in;
         phg_ff   <= phg_in;
      end
      axis_ff  <= axis_in;
      k_ff     <= k_in;
      hg_ff    <= hg_in;
      h_ff     <= h_in;
      neg_ff   <= neg_in;
      sq_ff    <= sq_in;
      sq_n_ff  <= sq_n_in;
      l_ff     <= l_in;
      num_ff   <= num_in;
      den_ff   <= den_in;
      tx_ff    <= tx_in;
      ty_ff    <= ty_in;
      acc_ff   <= acc_in;
      bsign_ff <= bsign_in;
      step_ff  <= step_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
   end

   assign res_valid      = (state_ff == M_OUT);
   assign res.dist_left  = dist_lane[0];
   assign res.dist_right = dist_lane[1];
   assign res.dist_up    = dist_lane[2];
   assign res.dist_down  = dist_lane[3];
   assign res.tilt_x     = tx_ff;
   assign res.tilt_y     = ty_ff;
   assign res.height     = hg_ff;
   assign res.cell_x     = cx_ff;
   assign res.cell_y     = cy_ff;

endmodule

`default_nettype wire

@@ design/ultrasonic_tilt_estimator_top.sv @@
// ---------------------------------------------------------------------------
// Ultrasonic tilt estimator
// Four echo lanes turn one shot into distances; a merge stage derives the
// height, the two tilts and their cells. Registers sit on an APB-style port.
// ---------------------------------------------------------------------------
//   Channel   Ports       Beat
//   input     req_*       four echo times and the echo mask of one shot
//   result    rsp_*       four distances, two tilts, height, two cells
//   config    csr_*       eight registers at byte address 4*index
//
// The four lanes run in parallel and pass through extra states when smoothing
// is on; the merge stage runs two 16-step square roots and up to four 30-step
// divisions on its one shared divider.
// Reset is synchronous and restores the registers and clears all smoothing
// history. A new shot is taken once the previous result sits in the output
// register; a stalled result holds there while the next shot is worked on.
// ---------------------------------------------------------------------------
`default_nettype none

module ultrasonic_tilt_estimator_top import ute_pkg::*; #(
   parameter int CELL_COUNT = CELL_COUNT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [SPEED_W-1:0]  speed_ff;
   logic [TIME_W-1:0]   max_time_ff;
   logic [ALPHA_W-1:0]  alpha_ff;
   logic [WEIGHT_W-1:0] weight_x_ff, weight_y_ff;
   logic [BASE_W-1:0]   base_x_ff, base_y_ff;
   logic [FLAGS_W-1:0]  flags_ff;

   logic                busy_ff, busy_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_payload_type     rsp_data_ff, rsp_data_in;

   csr_index_type       csr_index;
   logic                csr_write;
   logic [TIME_W-1:0]   wr_time;
   logic [ALPHA_W-1:0]  alpha_eff;
   cfg_type             cfg;
   logic                accept;
   logic                ack;
   logic [TIME_W-1:0]   echo [NUM_LANES];
   logic [NUM_LANES-1:0] lane_done;
   logic [DIST_W-1:0]   lane_dist [NUM_LANES];
   logic                res_valid;
   rsp_payload_type     res;

   assign csr_index  = csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign wr_time    = (csr_pwdata[TIME_W-1:0] > TIME_LIMIT) ? TIME_LIMIT
                                                             : csr_pwdata[TIME_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff    <= SOUND_SPEED_RST;
         max_time_ff <= MAX_TIME_RST;
         alpha_ff    <= ALPHA_RST;
         weight_x_ff <= WEIGHT_RST;
         weight_y_ff <= WEIGHT_RST;
         base_x_ff   <= BASELINE_RST;
         base_y_ff   <= BASELINE_RST;
         flags_ff    <= FLAGS_RST;
      end else if (csr_write) begin
         case (csr_index)
            REG_SOUND_SPEED: speed_ff    <= csr_pwdata[SPEED_W-1:0];
            REG_MAX_TIME:    max_time_ff <= wr_time;
            REG_ALPHA:       alpha_ff    <= csr_pwdata[ALPHA_W-1:0];
            REG_WEIGHT_X:    weight_x_ff <= csr_pwdata[WEIGHT_W-1:0];
            REG_WEIGHT_Y:    weight_y_ff <= csr_pwdata[WEIGHT_W-1:0];
            REG_BASELINE_X:  base_x_ff   <= csr_pwdata[BASE_W-1:0];
            REG_BASELINE_Y:  base_y_ff   <= csr_pwdata[BASE_W-1:0];
            REG_FLAGS:       flags_ff    <= csr_pwdata[FLAGS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_SOUND_SPEED: csr_prdata = CSR_DATA_W'(speed_ff);
         REG_MAX_TIME:    csr_prdata = CSR_DATA_W'(max_time_ff);
         REG_ALPHA:       csr_prdata = CSR_DATA_W'(alpha_ff);
         REG_WEIGHT_X:    csr_prdata = CSR_DATA_W'(weight_x_ff);
         REG_WEIGHT_Y:    csr_prdata = CSR_DATA_W'(weight_y_ff);
         REG_BASELINE_X:  csr_prdata = CSR_DATA_W'(base_x_ff);
         REG_BASELINE_Y:  csr_prdata = CSR_DATA_W'(base_y_ff);
         REG_FLAGS:       csr_prdata = CSR_DATA_W'(flags_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // Weights above one thousandth scale count as full weight on the new value.
   assign alpha_eff      = (alpha_ff > ALPHA_ONE) ? ALPHA_ONE : alpha_ff;
   assign cfg.sound_speed = speed_ff;
   assign cfg.max_time    = max_time_ff;
   assign cfg.alpha       = alpha_eff;
   assign cfg.alpha_rest  = ALPHA_ONE - alpha_eff;
   assign cfg.weight_x    = weight_x_ff;
   assign cfg.weight_y    = weight_y_ff;
   assign cfg.baseline_x  = base_x_ff;
   assign cfg.baseline_y  = base_y_ff;
   assign cfg.flags       = flags_ff;

   assign accept  = req_valid && !busy_ff;
   assign ack     = !rsp_valid_ff || !rsp_stall;
   assign echo[0] = req_data.echo_left_us;
   assign echo[1] = req_data.echo_right_us;
   assign echo[2] = req_data.echo_up_us;
   assign echo[3] = req_data.echo_down_us;

   for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
      ute_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .start   (accept),
         .echo_us (echo[i]),
         .seen    (req_data.echo_seen[i]),
         .cfg     (cfg),
         .done    (lane_done[i]),
         .dist_mm (lane_dist[i])
      );
   end

   ute_merge #(
      .CELL_COUNT (CELL_COUNT)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .start     (&lane_done),
      .dist_lane (lane_dist),
      .cfg       (cfg),
      .ack       (ack),
      .res_valid (res_valid),
      .res       (res)
   );

   always_comb begin
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         busy_in = 1'b1;
      end
      if (res_valid && ack) begin
         busy_in      = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

@@ design/ute_checker.sv @@
// ---------------------------------------------------------------------------
// Tilt estimator port checker
// Watches the top level's ports for ordering and result consistency.
// ---------------------------------------------------------------------------
`default_nettype none
`include "ultrasonic_tilt_estimator_top_macros.svh"

module ute_checker import ute_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input req_payload_type       req_data,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input rsp_payload_type       rsp_data,
   input logic                  csr_psel,
   input logic                  csr_penable,
   input logic                  csr_pwrite,
   input logic [CSR_ADDR_W-1:0] csr_paddr,
   input logic [CSR_DATA_W-1:0] csr_pwdata,
   input logic [CSR_DATA_W-1:0] csr_prdata,
   input logic                  csr_pready
);

   `UTE_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "result beat changed while stalled")
   `UTE_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "second shot taken while one is in flight")
   `UTE_ASSERT_SAME(a_result_from_work, $rose(rsp_valid), $past(req_stall), "result appeared without a shot in flight")
   `UTE_ASSERT_SAME(a_cell_x_zero, rsp_valid && rsp_data.tilt_x == 16'sd0, rsp_data.cell_x == 8'sd0, "nonzero cell for zero tilt")

endmodule

bind ultrasonic_tilt_estimator_top ute_checker u_checker (.*);

`default_nettype wire
